// ===== design/chae_pkg.sv =====
// ----------------------------------------------------------------------------
// chae_pkg
// shared types, codes and helpers of the convex hull area engine
// ----------------------------------------------------------------------------
package chae_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int AREA_W  = 34;
  localparam int PCNT_W  = 7;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_HULL   = 2'd3
  } opcode_t;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // sort order: by x, then by y
  function automatic logic pt_before(pt_t a, pt_t b);
    pt_before = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

// ===== design/chae_mul.sv =====
// ----------------------------------------------------------------------------
// chae_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module chae_mul (
  input  logic                                 clk,
  input  logic signed [chae_pkg::DIFF_W-1:0]   a,
  input  logic signed [chae_pkg::DIFF_W-1:0]   b,
  output logic signed [chae_pkg::PROD_W-1:0]   p
);
  import chae_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/convex_hull_area_engine.sv =====
// ----------------------------------------------------------------------------
// convex_hull_area_engine
// point set store with monotone chain hull and twice-area output
// ----------------------------------------------------------------------------
// operation: clear and add go straight to the result; remove scans the store
//   for the point and shifts the tail down; hull runs an insertion sort through
//   one read port, then the turn tests and the area edges on the single shared
//   multiplier
// throughput: one transaction at a time, in_ready only while idle; a finished
//   result waits in the output register while the next transaction is taken
// reset: synchronous active low, clears count, sticky flag, threshold to 51200
// ----------------------------------------------------------------------------
module convex_hull_area_engine #(
  parameter int MAX_POINTS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input transactions
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [chae_pkg::OP_W-1:0]             in_opcode,
  input  logic signed [chae_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [chae_pkg::COORD_W-1:0]   in_point_y,
  // result transactions
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [chae_pkg::STAT_W-1:0]           out_status,
  output logic [chae_pkg::AREA_W-1:0]           out_area_x2,
  output logic [chae_pkg::PCNT_W-1:0]           out_point_count,
  output logic                                  out_area_at_or_above,
  output logic                                  out_dropped_below,
  // threshold register write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [chae_pkg::AREA_W-1:0]           cfg_area_threshold_x2
);
  import chae_pkg::*;

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int HW  = $clog2(2 * MAX_POINTS);
  localparam int HCW = HW + 1;
  localparam int SW  = AREA_W + HW + 1;
  localparam logic [AREA_W-1:0] THR_RESET = AREA_W'(51200);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIN,
    ST_RM_RD, ST_RM_CHK, ST_SH_RD, ST_SH_WR,
    ST_SO_LD, ST_SO_KEY, ST_SO_RD, ST_SO_CMP,
    ST_HU_RD, ST_HU_LAT, ST_HU_CHK, ST_HU_DIF, ST_HU_M1, ST_HU_M2, ST_HU_CMP,
    ST_AR_RD, ST_AR_LAT, ST_AR_M2, ST_AR_ACC, ST_TH
  } state_t;

  // control and working registers
  state_t                    state_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             idx_r;
  logic [IW-1:0]             j_r;
  pt_t                       key_r;
  pt_t                       p_r;
  logic [HCW-1:0]            h_r;
  logic [HCW-1:0]            lo_r;
  logic [HCW-1:0]            ai_r;
  logic                      upper_r;
  logic                      push_r;
  logic signed [DIFF_W-1:0]  d1_r, d2_r, d3_r, d4_r;
  logic signed [PROD_W-1:0]  prod1_r;
  logic signed [SW-1:0]      sum_r;
  pt_t                       ea_r, eb_r;
  logic [AREA_W-1:0]         thr_r;
  logic                      was_above_r;
  logic [STAT_W-1:0]         res_status_r;
  logic [AREA_W-1:0]         res_area_r;
  logic                      res_above_r;
  logic                      res_dropped_r;
  logic                      out_valid_r;
  logic [STAT_W-1:0]         out_status_r;
  logic [AREA_W-1:0]         out_area_r;
  logic [PCNT_W-1:0]         out_count_r;
  logic                      out_above_r;
  logic                      out_dropped_r;

  // memories: point store, sorted copy, hull stack
  pt_t ps_mem [MAX_POINTS];
  pt_t so_mem [MAX_POINTS];
  pt_t hs_mem [2*MAX_POINTS];

  logic           ps_we, so_we, hs_we;
  logic [IW-1:0]  ps_waddr, ps_raddr, so_waddr, so_raddr;
  logic [HW-1:0]  hs_waddr, hs_ra, hs_rb;
  pt_t            ps_wdata, so_wdata, hs_wdata;
  pt_t            ps_rd, so_rd, hs_rda, hs_rdb;

  // shared multiplier
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic                      accept;
  opcode_t                   in_op;
  pt_t                       in_pt;
  logic [HCW-1:0]            hm1, hm2, ai_nx;
  logic [CW-1:0]             idx_inc;
  logic                      hull_test;
  logic signed [SW-1:0]      sum_abs;
  logic [AREA_W-1:0]         area_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_op     = opcode_t'(in_opcode);
  assign in_pt     = '{x: in_point_x, y: in_point_y};
  assign hm1       = h_r - HCW'(1);
  assign hm2       = h_r - HCW'(2);
  assign ai_nx     = ai_r + HCW'(1);
  assign idx_inc   = idx_r + CW'(1);
  // lower chain needs two on the stack, upper chain must stay above the lower one
  assign hull_test = !push_r && (upper_r ? (h_r > lo_r) : (h_r >= HCW'(2)));
  assign sum_abs   = sum_r[SW-1] ? -sum_r : sum_r;
  assign area_w    = sum_abs[AREA_W-1:0];

  chae_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (ps_we) begin
      ps_mem[ps_waddr] <= ps_wdata;
    end
    ps_rd <= ps_mem[ps_raddr];
  end

  always_ff @(posedge clk) begin
    if (so_we) begin
      so_mem[so_waddr] <= so_wdata;
    end
    so_rd <= so_mem[so_raddr];
  end

  always_ff @(posedge clk) begin
    if (hs_we) begin
      hs_mem[hs_waddr] <= hs_wdata;
    end
    hs_rda <= hs_mem[hs_ra];
    hs_rdb <= hs_mem[hs_rb];
  end

  // memory ports and multiplier operands by state
  always_comb begin
    ps_we    = 1'b0;
    ps_waddr = idx_r[IW-1:0];
    ps_wdata = ps_rd;
    ps_raddr = idx_r[IW-1:0];
    so_we    = 1'b0;
    so_waddr = j_r;
    so_wdata = key_r;
    so_raddr = idx_r[IW-1:0];
    hs_we    = 1'b0;
    hs_waddr = h_r[HW-1:0];
    hs_wdata = p_r;
    hs_ra    = hm2[HW-1:0];
    hs_rb    = hm1[HW-1:0];
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_IDLE: begin
        // append happens right at the accept edge
        if (accept && (in_op == OP_ADD) && (cnt_r < CW'(MAX_POINTS))) begin
          ps_we    = 1'b1;
          ps_waddr = cnt_r[IW-1:0];
          ps_wdata = in_pt;
        end
      end
      ST_SH_RD: begin
        ps_raddr = idx_inc[IW-1:0];
      end
      ST_SH_WR: begin
        ps_we = 1'b1;
      end
      ST_SO_RD: begin
        so_raddr = j_r - IW'(1);
        if (j_r == '0) begin
          so_we = 1'b1;
        end
      end
      ST_SO_CMP: begin
        so_we = 1'b1;
        if (pt_before(key_r, so_rd)) begin
          so_wdata = so_rd;
        end
      end
      ST_HU_CHK: begin
        if (!hull_test) begin
          hs_we = 1'b1;
        end
      end
      ST_HU_M1: begin
        mul_a = d1_r;
        mul_b = d2_r;
      end
      ST_HU_M2: begin
        mul_a = d3_r;
        mul_b = d4_r;
      end
      ST_AR_RD: begin
        hs_ra = ai_r[HW-1:0];
        hs_rb = (ai_nx < h_r) ? ai_nx[HW-1:0] : '0;
      end
      ST_AR_LAT: begin
        mul_a = $signed({hs_rda.x[COORD_W-1], hs_rda.x});
        mul_b = $signed({hs_rdb.y[COORD_W-1], hs_rdb.y});
      end
      ST_AR_M2: begin
        mul_a = $signed({eb_r.x[COORD_W-1], eb_r.x});
        mul_b = $signed({ea_r.y[COORD_W-1], ea_r.y});
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      was_above_r <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_area_threshold_x2;
      end
      // in ST_FIN the output register is reloaded below
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            p_r           <= in_pt;
            idx_r         <= '0;
            res_status_r  <= STAT_OK;
            res_area_r    <= '0;
            res_above_r   <= 1'b0;
            res_dropped_r <= 1'b0;
            case (in_op)
              OP_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_FIN;
              end
              OP_ADD: begin
                if (cnt_r < CW'(MAX_POINTS)) begin
                  cnt_r <= cnt_r + CW'(1);
                end else begin
                  res_status_r <= STAT_FULL;
                end
                state_r <= ST_FIN;
              end
              OP_REMOVE: begin
                state_r <= ST_RM_RD;
              end
              OP_HULL: begin
                h_r     <= '0;
                ai_r    <= '0;
                sum_r   <= '0;
                state_r <= (cnt_r == '0) ? ST_AR_RD : ST_SO_LD;
              end
              default: begin
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        // remove: linear scan, then shift the tail down one slot
        ST_RM_RD: begin
          if (idx_r >= cnt_r) begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= ST_FIN;
          end else begin
            state_r <= ST_RM_CHK;
          end
        end
        ST_RM_CHK: begin
          if (ps_rd == p_r) begin
            state_r <= ST_SH_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= ST_RM_RD;
          end
        end
        ST_SH_RD: begin
          if (idx_inc < cnt_r) begin
            state_r <= ST_SH_WR;
          end else begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= ST_FIN;
          end
        end
        ST_SH_WR: begin
          idx_r   <= idx_inc;
          state_r <= ST_SH_RD;
        end
        // insertion sort from the store into the sorted copy
        ST_SO_LD: begin
          state_r <= ST_SO_KEY;
        end
        ST_SO_KEY: begin
          key_r   <= ps_rd;
          j_r     <= idx_r[IW-1:0];
          state_r <= ST_SO_RD;
        end
        ST_SO_RD: begin
          if (j_r == '0) begin
            if (idx_inc == cnt_r) begin
              idx_r   <= '0;
              upper_r <= 1'b0;
              state_r <= ST_HU_RD;
            end else begin
              idx_r   <= idx_inc;
              state_r <= ST_SO_LD;
            end
          end else begin
            state_r <= ST_SO_CMP;
          end
        end
        ST_SO_CMP: begin
          if (pt_before(key_r, so_rd)) begin
            j_r     <= j_r - IW'(1);
            state_r <= ST_SO_RD;
          end else if (idx_inc == cnt_r) begin
            idx_r   <= '0;
            upper_r <= 1'b0;
            state_r <= ST_HU_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= ST_SO_LD;
          end
        end
        // monotone chain: lower pass up the sorted list, upper pass back down
        ST_HU_RD: begin
          state_r <= ST_HU_LAT;
        end
        ST_HU_LAT: begin
          p_r     <= so_rd;
          push_r  <= 1'b0;
          state_r <= ST_HU_CHK;
        end
        ST_HU_CHK: begin
          if (hull_test) begin
            state_r <= ST_HU_DIF;
          end else begin
            h_r <= h_r + HCW'(1);
            if (!upper_r) begin
              if (idx_inc == cnt_r) begin
                if (cnt_r >= CW'(2)) begin
                  upper_r <= 1'b1;
                  lo_r    <= h_r + HCW'(1);
                  idx_r   <= cnt_r - CW'(2);
                  state_r <= ST_HU_RD;
                end else begin
                  // closing point is the first one again: drop it
                  h_r     <= h_r;
                  state_r <= ST_AR_RD;
                end
              end else begin
                idx_r   <= idx_inc;
                state_r <= ST_HU_RD;
              end
            end else if (idx_r == '0) begin
              h_r     <= h_r;
              state_r <= ST_AR_RD;
            end else begin
              idx_r   <= idx_r - CW'(1);
              state_r <= ST_HU_RD;
            end
          end
        end
        ST_HU_DIF: begin
          d1_r    <= $signed({hs_rdb.x[COORD_W-1], hs_rdb.x})
                   - $signed({hs_rda.x[COORD_W-1], hs_rda.x});
          d2_r    <= $signed({p_r.y[COORD_W-1], p_r.y})
                   - $signed({hs_rda.y[COORD_W-1], hs_rda.y});
          d3_r    <= $signed({hs_rdb.y[COORD_W-1], hs_rdb.y})
                   - $signed({hs_rda.y[COORD_W-1], hs_rda.y});
          d4_r    <= $signed({p_r.x[COORD_W-1], p_r.x})
                   - $signed({hs_rda.x[COORD_W-1], hs_rda.x});
          state_r <= ST_HU_M1;
        end
        ST_HU_M1: begin
          state_r <= ST_HU_M2;
        end
        ST_HU_M2: begin
          prod1_r <= mul_p;
          state_r <= ST_HU_CMP;
        end
        ST_HU_CMP: begin
          // cross <= 0: right turn or collinear, pop the top
          if (prod1_r <= mul_p) begin
            h_r <= hm1;
          end else begin
            push_r <= 1'b1;
          end
          state_r <= ST_HU_CHK;
        end
        // shoelace sum around the hull
        ST_AR_RD: begin
          state_r <= (ai_r >= h_r) ? ST_TH : ST_AR_LAT;
        end
        ST_AR_LAT: begin
          ea_r    <= hs_rda;
          eb_r    <= hs_rdb;
          state_r <= ST_AR_M2;
        end
        ST_AR_M2: begin
          prod1_r <= mul_p;
          state_r <= ST_AR_ACC;
        end
        ST_AR_ACC: begin
          sum_r   <= sum_r + SW'(prod1_r) - SW'(mul_p);
          ai_r    <= ai_nx;
          state_r <= ST_AR_RD;
        end
        ST_TH: begin
          res_area_r <= area_w;
          if (area_w >= thr_r) begin
            res_above_r <= 1'b1;
            was_above_r <= 1'b1;
          end else if (was_above_r) begin
            res_dropped_r <= 1'b1;
          end
          state_r <= ST_FIN;
        end
        // result goes out once the output register is free
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= res_status_r;
            out_area_r    <= res_area_r;
            out_count_r   <= PCNT_W'(cnt_r);
            out_above_r   <= res_above_r;
            out_dropped_r <= res_dropped_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_area_x2          = out_area_r;
  assign out_point_count      = out_count_r;
  assign out_area_at_or_above = out_above_r;
  assign out_dropped_below    = out_dropped_r;

endmodule

// ===== design/chae_checker.sv =====
// ----------------------------------------------------------------------------
// chae_checker
// port level checks of the convex hull area engine results
// ----------------------------------------------------------------------------
module chae_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [chae_pkg::STAT_W-1:0]    out_status,
  input logic [chae_pkg::AREA_W-1:0]    out_area_x2,
  input logic                           out_area_at_or_above,
  input logic                           out_dropped_below
);
  import chae_pkg::*;

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NOT_FOUND ||
                   out_status == STAT_FULL))
    else $error("undefined status code");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_area_at_or_above |-> !out_dropped_below)
    else $error("above and dropped both set");

  a_err_no_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |->
      out_area_x2 == '0 && !out_area_at_or_above && !out_dropped_below)
    else $error("failed transaction carries area result");

endmodule

bind convex_hull_area_engine chae_checker u_chae_checker (.*);
